// ----- hdl/gpm_pkg.sv -----
// gpm_pkg: shared types and constants for the gesture pointer mapper.
// Used by gpm_pixel_map and gesture_pointer_mapper; depends on nothing.

package gpm_pkg;

  localparam int unsigned DIR_W   = 16;
  localparam int unsigned POS_W   = 14;
  localparam int unsigned DIFF_W  = POS_W + 1;
  localparam int unsigned COORD_W = 12;
  localparam int unsigned HOLD_W  = 8;
  localparam int unsigned THR_W   = 15;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DATA_W = 16;

  typedef logic [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    SWIPE_NONE  = 2'd0,
    SWIPE_LEFT  = 2'd1,
    SWIPE_RIGHT = 2'd2
  } swipe_ev_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SWIPE_THRESHOLD   = 4'd0,
    REG_HOLDOFF_FRAMES    = 4'd1,
    REG_PRESS_THRESHOLD   = 4'd2,
    REG_RELEASE_THRESHOLD = 4'd3,
    REG_X_LEFT_EDGE       = 4'd4,
    REG_Y_TOP_EDGE        = 4'd5,
    REG_SCREEN_WIDTH      = 4'd6,
    REG_SCREEN_HEIGHT     = 4'd7
  } reg_idx_t;

  localparam logic [THR_W-1:0]   RST_SWIPE_THRESHOLD   = 15'd11469;
  localparam logic [HOLD_W-1:0]  RST_HOLDOFF_FRAMES    = 8'd100;
  localparam logic [DIR_W-1:0]   RST_PRESS_THRESHOLD   = 16'hF99A;
  localparam logic [DIR_W-1:0]   RST_RELEASE_THRESHOLD = 16'h0000;
  localparam logic [POS_W-1:0]   RST_X_LEFT_EDGE       = 14'h3880;
  localparam logic [POS_W-1:0]   RST_Y_TOP_EDGE        = 14'd4000;
  localparam logic [COORD_W-1:0] RST_SCREEN_WIDTH      = 12'd1440;
  localparam logic [COORD_W-1:0] RST_SCREEN_HEIGHT     = 12'd900;

  // one result transaction
  typedef struct packed {
    swipe_ev_t swipe_event;
    logic      pointer_valid;
    coord_t    pointer_col;
    coord_t    pointer_row;
    logic      tap_event;
    coord_t    tap_col;
    coord_t    tap_row;
  } result_t;

endpackage

// ----- hdl/gesture_pointer_mapper.sv -----
// gesture_pointer_mapper: top level, frame handshake, configuration and gesture state.
// Depends on gpm_pkg and gpm_pixel_map.

// One tracking frame in, one result out, at one frame per clock sustained while
// out_ready stays high. A frame is captured into an input register and, in the
// cycle it moves to the output register, is evaluated against the holdoff counter
// and press state, so out_valid rises once the frame has passed the input register
// and reached the output register. While a result waits, the input register can
// still take one frame and then holds in_ready low. Configuration is written through
// cfg_we with register index cfg_index; indexes 8 and above are ignored.

module gesture_pointer_mapper #(
  parameter int unsigned PIXEL_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [gpm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gpm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_swipe_present,
  input  logic signed [gpm_pkg::DIR_W-1:0]    in_swipe_dir_x,
  input  logic                                in_finger_present,
  input  logic signed [gpm_pkg::POS_W-1:0]    in_tip_x,
  input  logic signed [gpm_pkg::POS_W-1:0]    in_tip_y,
  input  logic signed [gpm_pkg::DIR_W-1:0]    in_touch_distance,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_swipe_event,
  output logic                                out_pointer_valid,
  output logic [gpm_pkg::COORD_W-1:0]         out_pointer_col,
  output logic [gpm_pkg::COORD_W-1:0]         out_pointer_row,
  output logic                                out_tap_event,
  output logic [gpm_pkg::COORD_W-1:0]         out_tap_col,
  output logic [gpm_pkg::COORD_W-1:0]         out_tap_row
);

  // configuration registers
  logic [gpm_pkg::THR_W-1:0]        swipe_thr_r;
  logic [gpm_pkg::HOLD_W-1:0]       holdoff_frames_r;
  logic signed [gpm_pkg::DIR_W-1:0] press_thr_r;
  logic signed [gpm_pkg::DIR_W-1:0] release_thr_r;
  logic signed [gpm_pkg::POS_W-1:0] x_left_r;
  logic signed [gpm_pkg::POS_W-1:0] y_top_r;
  gpm_pkg::coord_t                  scr_w_r;
  gpm_pkg::coord_t                  scr_h_r;

  // input register
  logic                             s1_valid_r;
  logic                             s1_swipe_r;
  logic signed [gpm_pkg::DIR_W-1:0] s1_dir_r;
  logic                             s1_finger_r;
  logic signed [gpm_pkg::POS_W-1:0] s1_tx_r;
  logic signed [gpm_pkg::POS_W-1:0] s1_ty_r;
  logic signed [gpm_pkg::DIR_W-1:0] s1_td_r;

  // state
  logic [gpm_pkg::HOLD_W-1:0] holdoff_r, holdoff_nxt;
  logic                       armed_r, armed_nxt;
  gpm_pkg::coord_t            held_col_r, held_col_nxt;
  gpm_pkg::coord_t            held_row_r, held_row_nxt;

  // output register
  logic              out_valid_r;
  gpm_pkg::result_t  res_r, res_nxt;

  logic s1_adv;
  logic [gpm_pkg::HOLD_W-1:0] hold_dec;
  logic signed [gpm_pkg::DIR_W:0] dir_ext;
  logic signed [gpm_pkg::DIR_W:0] thr_pos;
  logic signed [gpm_pkg::DIR_W:0] thr_neg;
  gpm_pkg::swipe_ev_t ev;
  logic signed [gpm_pkg::DIFF_W-1:0] col_diff;
  logic signed [gpm_pkg::DIFF_W-1:0] row_diff;
  gpm_pkg::coord_t col_px;
  gpm_pkg::coord_t row_px;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swipe_thr_r      <= gpm_pkg::RST_SWIPE_THRESHOLD;
      holdoff_frames_r <= gpm_pkg::RST_HOLDOFF_FRAMES;
      press_thr_r      <= gpm_pkg::RST_PRESS_THRESHOLD;
      release_thr_r    <= gpm_pkg::RST_RELEASE_THRESHOLD;
      x_left_r         <= gpm_pkg::RST_X_LEFT_EDGE;
      y_top_r          <= gpm_pkg::RST_Y_TOP_EDGE;
      scr_w_r          <= gpm_pkg::RST_SCREEN_WIDTH;
      scr_h_r          <= gpm_pkg::RST_SCREEN_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        gpm_pkg::REG_SWIPE_THRESHOLD:   swipe_thr_r      <= cfg_wdata[gpm_pkg::THR_W-1:0];
        gpm_pkg::REG_HOLDOFF_FRAMES:    holdoff_frames_r <= cfg_wdata[gpm_pkg::HOLD_W-1:0];
        gpm_pkg::REG_PRESS_THRESHOLD:   press_thr_r      <= cfg_wdata;
        gpm_pkg::REG_RELEASE_THRESHOLD: release_thr_r    <= cfg_wdata;
        gpm_pkg::REG_X_LEFT_EDGE:       x_left_r         <= cfg_wdata[gpm_pkg::POS_W-1:0];
        gpm_pkg::REG_Y_TOP_EDGE:        y_top_r          <= cfg_wdata[gpm_pkg::POS_W-1:0];
        gpm_pkg::REG_SCREEN_WIDTH:      scr_w_r          <= cfg_wdata[gpm_pkg::COORD_W-1:0];
        gpm_pkg::REG_SCREEN_HEIGHT:     scr_h_r          <= cfg_wdata[gpm_pkg::COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_swipe_r  <= in_swipe_present;
      s1_dir_r    <= in_swipe_dir_x;
      s1_finger_r <= in_finger_present;
      s1_tx_r     <= in_tip_x;
      s1_ty_r     <= in_tip_y;
      s1_td_r     <= in_touch_distance;
    end
  end

  assign col_diff = $signed({s1_tx_r[gpm_pkg::POS_W-1], s1_tx_r})
                  - $signed({x_left_r[gpm_pkg::POS_W-1], x_left_r});
  assign row_diff = $signed({y_top_r[gpm_pkg::POS_W-1], y_top_r})
                  - $signed({s1_ty_r[gpm_pkg::POS_W-1], s1_ty_r});

  gpm_pixel_map #(.PIXEL_BITS(PIXEL_BITS)) u_col_map (
    .diff  (col_diff),
    .size  (scr_w_r),
    .pixel (col_px)
  );

  gpm_pixel_map #(.PIXEL_BITS(PIXEL_BITS)) u_row_map (
    .diff  (row_diff),
    .size  (scr_h_r),
    .pixel (row_px)
  );

  always_comb begin
    hold_dec = (holdoff_r != '0) ? holdoff_r - gpm_pkg::HOLD_W'(1) : '0;
    dir_ext  = (gpm_pkg::DIR_W+1)'(s1_dir_r);
    thr_pos  = $signed({2'b00, swipe_thr_r});
    thr_neg  = -thr_pos;
    if (dir_ext < thr_neg) begin
      ev = gpm_pkg::SWIPE_LEFT;
    end else if (dir_ext > thr_pos) begin
      ev = gpm_pkg::SWIPE_RIGHT;
    end else begin
      ev = gpm_pkg::SWIPE_NONE;
    end

    holdoff_nxt  = hold_dec;
    armed_nxt    = armed_r;
    held_col_nxt = held_col_r;
    held_row_nxt = held_row_r;
    res_nxt      = '0;
    res_nxt.swipe_event = gpm_pkg::SWIPE_NONE;

    if (hold_dec == '0 && s1_swipe_r && ev != gpm_pkg::SWIPE_NONE) begin
      armed_nxt   = 1'b0;
      holdoff_nxt = holdoff_frames_r;
      res_nxt.swipe_event = ev;
    end else if (!s1_finger_r) begin
      armed_nxt = 1'b0;
    end else begin
      if (armed_r) begin
        if (s1_td_r > release_thr_r) begin
          armed_nxt         = 1'b0;
          res_nxt.tap_event = 1'b1;
          res_nxt.tap_col   = held_col_r;
          res_nxt.tap_row   = held_row_r;
        end
      end else if (s1_td_r < press_thr_r) begin
        armed_nxt    = 1'b1;
        held_col_nxt = col_px;
        held_row_nxt = row_px;
      end
      res_nxt.pointer_valid = 1'b1;
      res_nxt.pointer_col   = col_px;
      res_nxt.pointer_row   = row_px;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holdoff_r  <= '0;
      armed_r    <= 1'b0;
      held_col_r <= '0;
      held_row_r <= '0;
    end else if (s1_adv) begin
      holdoff_r  <= holdoff_nxt;
      armed_r    <= armed_nxt;
      held_col_r <= held_col_nxt;
      held_row_r <= held_row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_swipe_event   = res_r.swipe_event;
  assign out_pointer_valid = res_r.pointer_valid;
  assign out_pointer_col   = res_r.pointer_col;
  assign out_pointer_row   = res_r.pointer_row;
  assign out_tap_event     = res_r.tap_event;
  assign out_tap_col       = res_r.tap_col;
  assign out_tap_row       = res_r.tap_row;

endmodule

// ----- hdl/gpm_pixel_map.sv -----
// gpm_pixel_map: scales a position offset in 1/16 mm to a clamped pixel at 6 px/mm.
// Depends on gpm_pkg.

module gpm_pixel_map #(
  parameter int unsigned PIXEL_BITS = 12
) (
  input  logic signed [gpm_pkg::DIFF_W-1:0] diff,
  input  gpm_pkg::coord_t                   size,
  output gpm_pkg::coord_t                   pixel
);

  localparam int unsigned PROD_W = gpm_pkg::DIFF_W + 4;
  localparam int unsigned LIM_W  = 17;
  localparam logic [LIM_W-1:0] PIX_MAX = LIM_W'((64'd1 << PIXEL_BITS) - 64'd1);

  logic signed [PROD_W-1:0] dx;
  logic signed [PROD_W-1:0] prod;
  logic [LIM_W-1:0]         size_m1;
  logic [LIM_W-1:0]         lim;
  logic [LIM_W-1:0]         quo;
  logic [LIM_W-1:0]         clamped;

  always_comb begin
    dx   = PROD_W'(diff);
    prod = (dx <<< 2) + (dx <<< 1);
    quo  = {4'd0, prod[PROD_W-3:4]};
    size_m1 = (size == '0) ? '0 : LIM_W'(size) - LIM_W'(1);
    lim = (size_m1 > PIX_MAX) ? PIX_MAX : size_m1;
    if (prod[PROD_W-1]) begin
      clamped = '0;
    end else if (quo > lim) begin
      clamped = lim;
    end else begin
      clamped = quo;
    end
    pixel = clamped[gpm_pkg::COORD_W-1:0];
  end

endmodule

// ----- test/tb_top.sv -----
// tb_top: self-checking testbench for gesture_pointer_mapper.
// Sends tracking frames with random idling and stalls, predicts each result and
// compares it. Depends on gpm_pkg and the gesture_pointer_mapper RTL.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gpm_pkg::*;

  localparam int DIR_LO = -16384;
  localparam int DIR_HI = 16384;
  localparam int POS_LO = -8192;
  localparam int POS_HI = 8191;
  localparam int PIX_MAX = (1 << COORD_W) - 1;
  localparam int TOTAL_FRAMES = 1850;
  localparam int RANDOM_PHASES = 6;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS = 40;
  localparam logic [CFG_IDX_W-1:0] FIRST_SPARE_IDX = 4'd8;

  typedef struct packed {
    logic                     swipe_present;
    logic signed [DIR_W-1:0]  swipe_dir_x;
    logic                     finger_present;
    logic signed [POS_W-1:0]  tip_x;
    logic signed [POS_W-1:0]  tip_y;
    logic signed [DIR_W-1:0]  touch_distance;
  } frame_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   in_swipe_present = 1'b0;
  logic signed [DIR_W-1:0] in_swipe_dir_x = '0;
  logic                   in_finger_present = 1'b0;
  logic signed [POS_W-1:0] in_tip_x = '0;
  logic signed [POS_W-1:0] in_tip_y = '0;
  logic signed [DIR_W-1:0] in_touch_distance = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [1:0]             out_swipe_event;
  logic                   out_pointer_valid;
  logic [COORD_W-1:0]     out_pointer_col;
  logic [COORD_W-1:0]     out_pointer_row;
  logic                   out_tap_event;
  logic [COORD_W-1:0]     out_tap_col;
  logic [COORD_W-1:0]     out_tap_row;

  // register shadows
  logic [THR_W-1:0]        sw_thr;
  logic [HOLD_W-1:0]       hold_frames;
  logic signed [DIR_W-1:0] press_thr;
  logic signed [DIR_W-1:0] rel_thr;
  logic signed [POS_W-1:0] x_left;
  logic signed [POS_W-1:0] y_top;
  logic [COORD_W-1:0]      scr_w;
  logic [COORD_W-1:0]      scr_h;

  // tracker state
  logic [HOLD_W-1:0] hold_cnt = '0;
  logic              armed = 1'b0;
  coord_t            held_col = '0;
  coord_t            held_row = '0;

  result_t pending_results[$];
  int errors = 0;
  int frames_sent = 0;
  int swipes_seen = 0;
  int taps_seen = 0;
  int settings_used = 0;
  int idle_cycles = 0;
  int ready_hold = 0;
  bit gaps_on = 1'b0;
  bit stalls_on = 1'b0;

  gesture_pointer_mapper DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_swipe_present  (in_swipe_present),
    .in_swipe_dir_x    (in_swipe_dir_x),
    .in_finger_present (in_finger_present),
    .in_tip_x          (in_tip_x),
    .in_tip_y          (in_tip_y),
    .in_touch_distance (in_touch_distance),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_swipe_event   (out_swipe_event),
    .out_pointer_valid (out_pointer_valid),
    .out_pointer_col   (out_pointer_col),
    .out_pointer_row   (out_pointer_row),
    .out_tap_event     (out_tap_event),
    .out_tap_col       (out_tap_col),
    .out_tap_row       (out_tap_row)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int rand_range(int lo, int hi);
    if (hi <= lo) return lo;
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return rand_range(1, 3);
    if (r < 95) return rand_range(4, 10);
    return rand_range(20, 60);
  endfunction

  function automatic frame_t mk_frame(bit sp, int dir, bit fp, int tx, int ty, int td);
    frame_t f;
    f.swipe_present  = sp;
    f.swipe_dir_x    = DIR_W'(clip(dir, DIR_LO, DIR_HI));
    f.finger_present = fp;
    f.tip_x          = POS_W'(clip(tx, POS_LO, POS_HI));
    f.tip_y          = POS_W'(clip(ty, POS_LO, POS_HI));
    f.touch_distance = DIR_W'(clip(td, DIR_LO, DIR_HI));
    return f;
  endfunction

  function automatic coord_t map_pixel(int diff, logic [COORD_W-1:0] size);
    int scaled, p, lim;
    scaled = diff * 6;
    if (scaled < 0) return '0;
    p = scaled >>> 4;
    lim = (size == 0) ? 0 : int'(size) - 1;
    if (lim > PIX_MAX) lim = PIX_MAX;
    if (p > lim) p = lim;
    return coord_t'(p);
  endfunction

  // expected result of one frame; advances the tracker state
  function automatic result_t track_frame(frame_t f);
    result_t r;
    int dir, thr;
    coord_t col, row;
    r = '0;
    if (hold_cnt != 0) hold_cnt--;
    if (hold_cnt == 0 && f.swipe_present) begin
      dir = int'(f.swipe_dir_x);
      thr = int'(sw_thr);
      if (dir < -thr) r.swipe_event = SWIPE_LEFT;
      else if (dir > thr) r.swipe_event = SWIPE_RIGHT;
      if (r.swipe_event != SWIPE_NONE) begin
        armed = 1'b0;
        hold_cnt = hold_frames;
        return r;
      end
    end
    if (!f.finger_present) begin
      armed = 1'b0;
      return r;
    end
    col = map_pixel(int'(f.tip_x) - int'(x_left), scr_w);
    row = map_pixel(int'(y_top) - int'(f.tip_y), scr_h);
    if (armed) begin
      if (f.touch_distance > rel_thr) begin
        armed = 1'b0;
        r.tap_event = 1'b1;
        r.tap_col = held_col;
        r.tap_row = held_row;
      end
    end else if (f.touch_distance < press_thr) begin
      armed = 1'b1;
      held_col = col;
      held_row = row;
    end
    r.pointer_valid = 1'b1;
    r.pointer_col = col;
    r.pointer_row = row;
    return r;
  endfunction

  task automatic load_reset_values();
    sw_thr = RST_SWIPE_THRESHOLD;
    hold_frames = RST_HOLDOFF_FRAMES;
    press_thr = RST_PRESS_THRESHOLD;
    rel_thr = RST_RELEASE_THRESHOLD;
    x_left = RST_X_LEFT_EDGE;
    y_top = RST_Y_TOP_EDGE;
    scr_w = RST_SCREEN_WIDTH;
    scr_h = RST_SCREEN_HEIGHT;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'(val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_SWIPE_THRESHOLD:   sw_thr = data[THR_W-1:0];
      REG_HOLDOFF_FRAMES:    hold_frames = data[HOLD_W-1:0];
      REG_PRESS_THRESHOLD:   press_thr = data;
      REG_RELEASE_THRESHOLD: rel_thr = data;
      REG_X_LEFT_EDGE:       x_left = data[POS_W-1:0];
      REG_Y_TOP_EDGE:        y_top = data[POS_W-1:0];
      REG_SCREEN_WIDTH:      scr_w = data[COORD_W-1:0];
      REG_SCREEN_HEIGHT:     scr_h = data[COORD_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_frame(frame_t f);
    int gap;
    result_t r;
    gap = (gaps_on && $urandom_range(0, 99) < 30) ? gap_len() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_swipe_present <= f.swipe_present;
    in_swipe_dir_x <= f.swipe_dir_x;
    in_finger_present <= f.finger_present;
    in_tip_x <= f.tip_x;
    in_tip_y <= f.tip_y;
    in_touch_distance <= f.touch_distance;
    do @(posedge clk); while (!in_ready);
    r = track_frame(f);
    if (r.swipe_event != SWIPE_NONE) swipes_seen++;
    if (r.tap_event) taps_seen++;
    pending_results.push_back(r);
    frames_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic int pick_setting(int lo, int hi, int typ_lo, int typ_hi);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return rand_range(typ_lo, typ_hi);
  endfunction

  function automatic int strong_dir();
    int m;
    m = rand_range(int'(sw_thr) + 1, DIR_HI);
    return $urandom_range(0, 1) ? m : -m;
  endfunction

  task automatic randomize_settings();
    int r, hv;
    r = $urandom_range(0, 19);
    hv = (r < 14) ? rand_range(0, 6) : (r < 18) ? rand_range(7, 40) :
         (r == 18) ? 255 : rand_range(41, 254);
    write_reg(REG_SWIPE_THRESHOLD, pick_setting(0, DIR_HI, 1000, 15000));
    write_reg(REG_HOLDOFF_FRAMES, int'({8'($urandom), 8'(hv)}));
    write_reg(REG_PRESS_THRESHOLD, pick_setting(DIR_LO, DIR_HI, -8000, 2000));
    write_reg(REG_RELEASE_THRESHOLD, pick_setting(DIR_LO, DIR_HI, -2000, 8000));
    write_reg(REG_X_LEFT_EDGE, pick_setting(POS_LO, POS_HI, POS_LO, POS_HI));
    write_reg(REG_Y_TOP_EDGE, pick_setting(POS_LO, POS_HI, POS_LO, POS_HI));
    write_reg(REG_SCREEN_WIDTH, pick_setting(0, PIX_MAX, 1, PIX_MAX));
    write_reg(REG_SCREEN_HEIGHT, pick_setting(0, PIX_MAX, 1, PIX_MAX));
    if ($urandom_range(0, 3) == 0)
      write_reg(FIRST_SPARE_IDX + CFG_IDX_W'($urandom_range(0, 7)), $urandom);
    settings_used++;
  endtask

  // one finger frame of a touch stroke, with drift and occasional disturbance
  task automatic send_touch(inout int bx, inout int by, input int td);
    int r;
    bit sp, fp;
    int dir;
    bx = clip(bx + rand_range(-40, 40), POS_LO, POS_HI);
    by = clip(by + rand_range(-40, 40), POS_LO, POS_HI);
    r = $urandom_range(0, 99);
    fp = (r >= 5);
    sp = (r >= 5 && r < 25) || (r >= 97);
    dir = (r >= 97) ? strong_dir() : rand_range(-int'(sw_thr), int'(sw_thr));
    send_frame(mk_frame(sp, dir, fp, bx, by, td));
  endtask

  task automatic send_stroke();
    int bx, by, i, n_hover, n_drag;
    bx = x_left + rand_range(-100, int'(scr_w) * 16 / 6 + 100);
    by = y_top - rand_range(-100, int'(scr_h) * 16 / 6 + 100);
    n_hover = rand_range(0, 2);
    n_drag = rand_range(0, 4);
    for (i = 0; i < n_hover; i++) send_touch(bx, by, rand_range(int'(press_thr), DIR_HI));
    send_touch(bx, by, rand_range(DIR_LO, int'(press_thr) - 1));
    for (i = 0; i < n_drag; i++) send_touch(bx, by, rand_range(DIR_LO, int'(rel_thr)));
    send_touch(bx, by, rand_range(int'(rel_thr) + 1, DIR_HI));
  endtask

  task automatic send_swipes();
    int i, n, dir, r;
    n = rand_range(1, 4);
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      case (r)
        0: dir = int'(sw_thr);
        1: dir = -int'(sw_thr);
        2: dir = int'(sw_thr) + 1;
        3: dir = -int'(sw_thr) - 1;
        default: dir = strong_dir();
      endcase
      send_frame(mk_frame(1'b1, dir, 1'($urandom_range(0, 1)),
                          x_left + rand_range(-100, 3000), y_top - rand_range(-100, 3000),
                          rand_range(DIR_LO, DIR_HI)));
    end
  endtask

  task automatic send_noise();
    send_frame(mk_frame(1'($urandom_range(0, 1)), rand_range(DIR_LO, DIR_HI),
                        1'($urandom_range(0, 1)), rand_range(POS_LO, POS_HI),
                        rand_range(POS_LO, POS_HI), rand_range(DIR_LO, DIR_HI)));
  endtask

  task automatic test_pointer_extremes();
    send_frame(mk_frame(1'b0, 0, 1'b1, POS_LO, POS_HI, DIR_HI));
    send_frame(mk_frame(1'b0, 0, 1'b1, POS_HI, POS_LO, 0));
    send_frame(mk_frame(1'b0, DIR_LO, 1'b0, POS_HI, POS_HI, DIR_LO));
    send_frame(mk_frame(1'b1, 11469, 1'b1, 0, 0, 0));
  endtask

  task automatic test_press_release();
    send_frame(mk_frame(1'b0, 0, 1'b1, 100, 2000, -1638));
    send_frame(mk_frame(1'b0, 0, 1'b1, 100, 2000, -1639));
    send_frame(mk_frame(1'b0, 0, 1'b1, 500, 1000, DIR_LO));
    send_frame(mk_frame(1'b0, 0, 1'b1, 500, 1000, 0));
    send_frame(mk_frame(1'b0, 0, 1'b1, 600, 900, 1));
    send_frame(mk_frame(1'b0, 0, 1'b1, 0, 0, DIR_LO));
    send_frame(mk_frame(1'b0, 0, 1'b0, 0, 0, DIR_HI));
    send_frame(mk_frame(1'b0, 0, 1'b1, 0, 0, DIR_HI));
  endtask

  task automatic test_swipe_holdoff();
    wait_idle();
    write_reg(REG_HOLDOFF_FRAMES, 2);
    settings_used++;
    send_frame(mk_frame(1'b0, 0, 1'b1, 0, 0, DIR_LO));
    send_frame(mk_frame(1'b1, 11469, 1'b1, 0, 0, 0));
    send_frame(mk_frame(1'b1, -11469, 1'b1, 0, 0, 0));
    send_frame(mk_frame(1'b1, 11470, 1'b1, 0, 0, DIR_HI));
    send_frame(mk_frame(1'b1, DIR_LO, 1'b1, 0, 0, DIR_HI));
    send_frame(mk_frame(1'b1, DIR_LO, 1'b0, 0, 0, 0));
  endtask

  task automatic test_register_extremes();
    wait_idle();
    write_reg(REG_HOLDOFF_FRAMES, 16'hFF00);
    write_reg(REG_SWIPE_THRESHOLD, 0);
    write_reg(REG_SCREEN_WIDTH, 0);
    write_reg(REG_SCREEN_HEIGHT, 0);
    write_reg(FIRST_SPARE_IDX, 16'hFFFF);
    write_reg(CFG_IDX_W'(15), 16'h1234);
    settings_used++;
    send_frame(mk_frame(1'b1, 0, 1'b1, 100, 100, 0));
    send_frame(mk_frame(1'b1, 1, 1'b1, POS_HI, POS_LO, 0));
    send_frame(mk_frame(1'b1, -1, 1'b1, POS_HI, POS_LO, 0));
    wait_idle();
    write_reg(REG_SWIPE_THRESHOLD, 16'hC000);
    write_reg(REG_SCREEN_WIDTH, PIX_MAX);
    write_reg(REG_SCREEN_HEIGHT, 1);
    write_reg(REG_PRESS_THRESHOLD, DIR_LO);
    write_reg(REG_RELEASE_THRESHOLD, DIR_HI);
    write_reg(REG_X_LEFT_EDGE, POS_LO);
    write_reg(REG_Y_TOP_EDGE, POS_HI);
    settings_used++;
    send_frame(mk_frame(1'b1, DIR_HI, 1'b1, POS_HI, POS_LO, DIR_LO));
    send_frame(mk_frame(1'b1, DIR_LO, 1'b1, POS_LO, POS_HI, DIR_HI));
  endtask

  task automatic test_random_traffic();
    int phase, quota, phase_start, r;
    quota = (TOTAL_FRAMES - frames_sent) / RANDOM_PHASES;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      randomize_settings();
      phase_start = frames_sent;
      gaps_on = (phase != 1) && $urandom_range(0, 3) != 0;
      stalls_on = (phase != 1) && $urandom_range(0, 3) != 0;
      while (frames_sent - phase_start < quota) begin
        if ($urandom_range(0, 29) == 0) begin
          gaps_on = (phase != 1) && $urandom_range(0, 1);
          stalls_on = (phase != 1) && $urandom_range(0, 1);
        end
        r = $urandom_range(0, 99);
        if (r < 45) send_stroke();
        else if (r < 70) send_swipes();
        else send_noise();
      end
    end
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(negedge clk) begin
    if (ready_hold != 0) begin
      ready_hold--;
      out_ready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 99) < 25) begin
      ready_hold = gap_len() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result transaction with no frame outstanding", $time);
      end else begin
        want = pending_results.pop_front();
        check_field("swipe_event", 32'(want.swipe_event), 32'(out_swipe_event));
        check_field("pointer_valid", 32'(want.pointer_valid), 32'(out_pointer_valid));
        check_field("pointer_col", 32'(want.pointer_col), 32'(out_pointer_col));
        check_field("pointer_row", 32'(want.pointer_row), 32'(out_pointer_row));
        check_field("tap_event", 32'(want.tap_event), 32'(out_tap_event));
        check_field("tap_col", 32'(want.tap_col), 32'(out_tap_col));
        check_field("tap_row", 32'(want.tap_row), 32'(out_tap_row));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    load_reset_values();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    settings_used++;
    test_pointer_extremes();
    test_press_release();
    test_swipe_holdoff();
    test_register_extremes();
    test_random_traffic();
    wait_idle();
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, pending_results.size());
    end
    $display("Frames sent: %0d over %0d register settings", frames_sent, settings_used);
    $display("Swipes predicted: %0d, taps predicted: %0d, errors: %0d",
             swipes_seen, taps_seen, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
